// ----- src/keyed_sponge_hash_64_macros.svh -----
// ----------------------------------------------------------------------------
// keyed_sponge_hash_64 assertion macros
// shared concurrent assertion forms on the block clock and reset
// ----------------------------------------------------------------------------
`ifndef KEYED_SPONGE_HASH_64_MACROS_SVH
`define KEYED_SPONGE_HASH_64_MACROS_SVH

// implication checked on every clock edge outside reset
`define KSH64_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define KSH64_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/ksh64_pkg.sv -----
// ----------------------------------------------------------------------------
// ksh64_pkg
// types, constants and round/padding functions of the keyed sponge hash
// ----------------------------------------------------------------------------
package ksh64_pkg;

   localparam int BlockLen   = 4;
   localparam int CountWidth = 4;
   localparam int StateBits  = 128;
   localparam int SeedBits   = 64;
   localparam int DataBits   = 32;
   localparam int InCntBits  = 3;
   localparam int RndCntBits = 3;

   localparam logic [RndCntBits-1:0] AbsorbRounds = 3'd2;
   localparam logic [RndCntBits-1:0] FinalRounds  = 3'd4;
   localparam logic [RndCntBits-1:0] AllRounds    = 3'd6;

   localparam logic [7:0] PadFirst = 8'h1F;
   localparam logic [7:0] PadLast  = 8'h80;
   localparam int         PadLastByte = 3;

   typedef logic [3:0][31:0] words_type;

   typedef struct packed {
      logic load;
      logic fresh;
      logic pad;
      logic round;
      logic out_load;
   } cmd_type;

   function automatic logic [CountWidth-1:0] eff_count(input logic [InCntBits-1:0] cnt);
      logic [CountWidth-1:0] wide;
      wide = CountWidth'(cnt);
      if (wide > CountWidth'(BlockLen)) begin
         return CountWidth'(BlockLen);
      end
      return wide;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic words_type arx_round(input words_type w);
      logic [31:0] a, b, c, d;
      a = w[0];
      b = w[1];
      c = w[2];
      d = w[3];
      a = a + b; b = rotl32(b, 5);  b = b ^ a; a = rotl32(a, 16);
      c = c + d; d = rotl32(d, 8);  d = d ^ c;
      a = a + d; d = rotl32(d, 13); d = d ^ a;
      c = c + b; b = rotl32(b, 7);  b = b ^ c; c = rotl32(c, 16);
      return {d, c, b, a};
   endfunction

   function automatic logic [StateBits-1:0] absorb_mask(input logic [DataBits-1:0] data,
                                                        input logic [CountWidth-1:0] n);
      logic [StateBits-1:0] m;
      m = '0;
      for (int i = 0; i < BlockLen; i++) begin
         if (CountWidth'(i) < n) begin
            m[8*(i%16)+:8] = (i < 4) ? data[8*(i%4)+:8] : 8'h00;
         end
      end
      return m;
   endfunction

   function automatic logic [StateBits-1:0] pad_mask(input logic [CountWidth-1:0] n);
      logic [StateBits-1:0] m;
      m = '0;
      m[8*PadLastByte+:8] = PadLast;
      m = m ^ (StateBits'(PadFirst) << (8 * int'(n)));
      return m;
   endfunction

endpackage

// ----- src/ksh64_datapath.sv -----
// ----------------------------------------------------------------------------
// ksh64_datapath
// seed register, hash state, round unit and digest output register
// ----------------------------------------------------------------------------
module ksh64_datapath
   import ksh64_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [DataBits-1:0]   req_data_bytes,
   input  logic [InCntBits-1:0]  req_byte_count,
   input  logic                  csr_write_enable,
   input  logic [SeedBits-1:0]   csr_write_data,
   output logic [SeedBits-1:0]   rsp_digest
);

   logic [SeedBits-1:0]   seed_ff, seed_in;
   words_type             words_ff, words_in;
   logic [CountWidth-1:0] n_ff, n_in;
   logic [SeedBits-1:0]   digest_ff, digest_in;

   logic [CountWidth-1:0] n_eff;
   logic [StateBits-1:0]  base;
   logic [StateBits-1:0]  pad_now;

   always_comb begin
      n_eff   = eff_count(req_byte_count);
      seed_in = csr_write_enable ? csr_write_data : seed_ff;
      base    = cmd.fresh ? {seed_ff[63:32], 32'h0, seed_ff[31:0], 32'h0} : words_ff;
      pad_now = '0;
      n_in    = n_ff;
      words_in = words_ff;
      if (cmd.load) begin
         n_in = n_eff;
         if (cmd.pad) begin
            pad_now = pad_mask(n_eff);
         end
         words_in = base ^ absorb_mask(req_data_bytes, n_eff) ^ pad_now;
      end else if (cmd.round) begin
         if (cmd.pad) begin
            pad_now = pad_mask(n_ff);
         end
         words_in = arx_round(words_ff ^ pad_now);
      end
      digest_in = cmd.out_load ? {words_ff[1], words_ff[0]} : digest_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         words_ff <= '0;
         n_ff     <= '0;
      end else begin
         seed_ff  <= seed_in;
         words_ff <= words_in;
         n_ff     <= n_in;
      end
      digest_ff <= digest_in;
   end

   assign rsp_digest = digest_ff;

endmodule

// ----- src/ksh64_ctrl.sv -----
// ----------------------------------------------------------------------------
// ksh64_ctrl
// sequencer for load, round and output steps plus both handshakes
// ----------------------------------------------------------------------------
`include "keyed_sponge_hash_64_macros.svh"

module ksh64_ctrl
   import ksh64_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [InCntBits-1:0] req_byte_count,
   input  logic                 req_last_block,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output cmd_type              cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [RndCntBits-1:0] cnt_ff, cnt_in;
   logic                  last_ff, last_in;
   logic                  pad_pend_ff, pad_pend_in;
   logic                  mid_ff, mid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CountWidth-1:0] n_eff;
   logic                  accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      n_eff        = eff_count(req_byte_count);
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      pad_pend_in  = pad_pend_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (n_eff != '0 || req_last_block)) begin
               cmd.load    = 1'b1;
               cmd.fresh   = !mid_ff;
               cmd.pad     = (n_eff == '0);
               mid_in      = !req_last_block;
               last_in     = req_last_block;
               pad_pend_in = req_last_block && (n_eff != '0);
               if (n_eff == '0) begin
                  cnt_in = FinalRounds;
               end else if (req_last_block) begin
                  cnt_in = AllRounds;
               end else begin
                  cnt_in = AbsorbRounds;
               end
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.round = 1'b1;
            cmd.pad   = pad_pend_ff && (cnt_ff == FinalRounds);
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == RndCntBits'(1)) begin
               state_in = last_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         pad_pend_ff  <= 1'b0;
         mid_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         pad_pend_ff  <= pad_pend_in;
         mid_ff       <= mid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // round counter never runs dry inside a round sequence
   `KSH64_ASSERT(a_run_cnt, (state_ff == S_RUN) |-> (cnt_ff != '0), "round count zero in run")
   // padding inside the round sequence only for a closing transaction
   `KSH64_ASSERT(a_pad_last, (cmd.round && cmd.pad) |-> last_ff, "padding on non-last item")
   // digest capture always raises the response
   `KSH64_ASSERT(a_out_valid, cmd.out_load |=> rsp_valid_ff, "digest loaded without valid")
   // an absorbed non-last transaction leaves the message open
   `KSH64_ASSERT(a_mid_open, (cmd.load && !req_last_block) |=> mid_ff, "message not held open")
   // no new transaction while the sequencer is busy
   `KSH64_ASSERT_ALWAYS(a_busy, (state_ff != S_IDLE) |-> !req_ready, "ready while busy")

endmodule

// ----- src/keyed_sponge_hash_64.sv -----
// ----------------------------------------------------------------------------
// keyed_sponge_hash_64
// keyed 64-bit sponge hash over a 128-bit ARX state, one round per cycle
// ----------------------------------------------------------------------------
// usage:
//   csr_write_data is the 64-bit seed, written when csr_write_enable is high;
//   it is sampled at the first transaction of each message.
//   req_* carries up to 4 message bytes, a byte count and a last flag; a
//   transaction is taken when req_valid and req_ready are both high.
//   rsp_* carries the 64-bit digest, one per message, after the last item.
// timing:
//   one arx round per cycle in a single shared round unit sets the rate.
//   a non-last item runs a load and 2 rounds before ready returns.
//   a last item with data runs a load, 6 rounds and a digest capture;
//   rsp_valid is raised by the capture. an empty last item runs a load,
//   4 rounds and a capture. a zero count without last loads nothing.
// stalls and reset:
//   the digest sits in an output register, so the next message is taken
//   while a digest waits; a second digest holds the block until rsp_ready.
//   synchronous reset clears the seed, the state and the response valid flag.
// ----------------------------------------------------------------------------
module keyed_sponge_hash_64
   import ksh64_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DataBits-1:0]  req_data_bytes,
   input  logic [InCntBits-1:0] req_byte_count,
   input  logic                 req_last_block,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SeedBits-1:0]  rsp_digest,
   input  logic                 csr_write_enable,
   input  logic [SeedBits-1:0]  csr_write_data
);

   cmd_type cmd;

   ksh64_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_byte_count (req_byte_count),
      .req_last_block (req_last_block),
      .req_ready      (req_ready),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .cmd            (cmd)
   );

   ksh64_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data_bytes   (req_data_bytes),
      .req_byte_count   (req_byte_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_digest       (rsp_digest)
   );

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: keyed_sponge_hash_64 testbench
// drives messages of byte items under several seeds with random idling on
// both channels and one long output stall, predicts each digest with an
// independent model of the sponge state and checks every returned digest
// ----------------------------------------------------------------------------
module tb;
   import ksh64_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 300;
   localparam int LongHold   = 400;
   localparam int SettleGap  = 12;

   typedef struct packed {
      logic [DataBits-1:0]  data;
      logic [InCntBits-1:0] count;
      logic                 last;
   } req_item_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [DataBits-1:0]  req_data_bytes   = '0;
   logic [InCntBits-1:0] req_byte_count   = '0;
   logic                 req_last_block   = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [SeedBits-1:0]  rsp_digest;
   logic                 csr_write_enable = 1'b0;
   logic [SeedBits-1:0]  csr_write_data   = '0;

   req_item_type        msg_items[$];
   logic [SeedBits-1:0] digests_due[$];

   logic [31:0]         sponge_words[4];
   logic                open_msg;
   logic [SeedBits-1:0] key_seed;

   logic req_taken  = 1'b0;
   logic calm       = 1'b0;
   logic hold_req   = 1'b0;
   logic hold_done  = 1'b0;
   int   hold_left  = 0;
   int   send_gap   = 0;
   int   recv_gap   = 0;
   int   cycles     = 0;
   int   mismatches = 0;
   int   items_taken       = 0;
   int   digests_predicted = 0;
   int   digests_checked   = 0;
   int   seed_writes       = 0;

   keyed_sponge_hash_64 u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_bytes   (req_data_bytes),
      .req_byte_count   (req_byte_count),
      .req_last_block   (req_last_block),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest       (rsp_digest),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned s);
      logic [63:0] twice;
      twice = {x, x} << s;
      return twice[63:32];
   endfunction

   task automatic permute(input int rounds);
      logic [31:0] a, b, c, d;
      a = sponge_words[0];
      b = sponge_words[1];
      c = sponge_words[2];
      d = sponge_words[3];
      for (int r = 0; r < rounds; r++) begin
         a = a + b; b = rol(b, 5) ^ a; a = rol(a, 16);
         c = c + d; d = rol(d, 8) ^ c;
         a = a + d; d = rol(d, 13) ^ a;
         c = c + b; b = rol(b, 7) ^ c; c = rol(c, 16);
      end
      sponge_words[0] = a;
      sponge_words[1] = b;
      sponge_words[2] = c;
      sponge_words[3] = d;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 100) begin
         $display("mismatch at cycle %0d: %s got %016h want %016h", cycles, what, got, want);
      end
   endtask

   // sponge state prediction on each accepted transaction
   always @(posedge clock) begin : predict_digest
      int n;
      req_taken <= !reset && req_valid && req_ready;
      if (reset) begin
         for (int w = 0; w < 4; w++) begin
            sponge_words[w] = '0;
         end
         open_msg = 1'b0;
         key_seed = '0;
      end else begin
         if (csr_write_enable) begin
            key_seed = csr_write_data;
         end
         if (req_valid && req_ready) begin
            items_taken++;
            n = (req_byte_count > 3'd4) ? 4 : int'(req_byte_count);
            if (n != 0 || req_last_block) begin
               if (!open_msg) begin
                  sponge_words[0] = '0;
                  sponge_words[1] = key_seed[31:0];
                  sponge_words[2] = '0;
                  sponge_words[3] = key_seed[63:32];
                  open_msg = 1'b1;
               end
               if (n != 0) begin
                  for (int i = 0; i < n; i++) begin
                     sponge_words[0] ^= {24'd0, req_data_bytes[8*i+:8]} << (8 * i);
                  end
                  permute(2);
               end
               if (req_last_block) begin
                  sponge_words[n / 4] ^= 32'h1F << (8 * (n % 4));
                  sponge_words[0] ^= 32'h80 << 24;
                  permute(4);
                  open_msg = 1'b0;
                  digests_due.push_back({sponge_words[1], sponge_words[0]});
                  digests_predicted++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : check_digests
      logic [63:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digests_due.size() == 0) begin
            report_mismatch("digest with no message pending", rsp_digest, '0);
         end else begin
            want = digests_due.pop_front();
            digests_checked++;
            if (rsp_digest !== want) begin
               report_mismatch("digest", rsp_digest, want);
            end
         end
      end
   end

   always @(negedge clock) begin : drive_requests
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         send_gap  <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         send_gap  <= $urandom_range(0, 13);
         req_valid <= 1'b0;
      end else if (msg_items.size() != 0) begin
         it = msg_items.pop_front();
         req_valid      <= 1'b1;
         req_data_bytes <= it.data;
         req_byte_count <= it.count;
         req_last_block <= it.last;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // long output stall so the block backs up and stalls its input
   always @(negedge clock) begin
      if (hold_req && !hold_done) begin
         hold_left <= LongHold;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_left > 0 || (hold_req && !hold_done)) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         recv_gap  <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic set_seed(input logic [63:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      seed_writes++;
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
      end while (msg_items.size() != 0 || req_valid || digests_due.size() != 0);
      repeat (SettleGap) @(posedge clock);
   endtask

   function automatic void push_item(input logic [31:0] data, input logic [2:0] count,
                                     input logic last);
      req_item_type it;
      it.data  = data;
      it.count = count;
      it.last  = last;
      msg_items.push_back(it);
   endfunction

   // one message: a body of mostly full items with some noise, then a last item
   function automatic int queue_message();
      int body;
      int counted;
      logic [2:0] cnt;
      body    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
      counted = 0;
      for (int k = 0; k < body; k++) begin
         case ($urandom_range(0, 9))
            0:       cnt = 3'($urandom_range(5, 7));
            1:       cnt = 3'($urandom_range(1, 3));
            2:       cnt = 3'd0;
            default: cnt = 3'd4;
         endcase
         push_item($urandom, cnt, 1'b0);
         if (cnt != 3'd0) begin
            counted++;
         end
      end
      push_item($urandom, 3'($urandom_range(0, 7)), 1'b1);
      return counted + 1;
   endfunction

   initial begin
      logic [63:0] s;
      int queued;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of count and data, empty and short items
      set_seed('0);
      push_item(32'h0000_0000, 3'd0, 1'b1);
      push_item(32'h5555_AAAA, 3'd0, 1'b0);
      push_item(32'hFFFF_FFFF, 3'd4, 1'b1);
      push_item(32'h0000_0000, 3'd1, 1'b1);
      push_item(32'hA5A5_A5A5, 3'd2, 1'b1);
      push_item(32'h1234_5678, 3'd3, 1'b1);
      push_item(32'hFFFF_FFFF, 3'd7, 1'b1);
      push_item(32'h0123_4567, 3'd4, 1'b0);
      push_item(32'h89AB_CDEF, 3'd5, 1'b0);
      push_item(32'hFFFF_FFFF, 3'd0, 1'b1);
      push_item(32'hDEAD_BEEF, 3'd2, 1'b0);
      push_item(32'h0000_0000, 3'd0, 1'b0);
      push_item(32'hCAFE_F00D, 3'd6, 1'b1);
      drain();
      set_seed('1);
      push_item(32'h0000_0000, 3'd0, 1'b1);
      push_item(32'hFFFF_FFFF, 3'd4, 1'b0);
      push_item(32'hFFFF_FFFF, 3'd4, 1'b1);
      push_item(32'h8000_0001, 3'd1, 1'b0);
      push_item(32'h7FFF_FFFE, 3'd3, 1'b1);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            1:       s = 64'h8000_0000_0000_0001;
            3:       s = '1;
            5:       s = '0;
            default: s = {$urandom, $urandom};
         endcase
         set_seed(s);
         if (p == 3) begin
            hold_req <= 1'b1;
         end
         if (p == 5) begin
            calm <= 1'b1;
         end
         queued = 0;
         while (queued < PhaseItems) begin
            queued += queue_message();
         end
         drain();
      end

      $display("covered %0d accepted transactions in %0d messages under %0d seed values",
               items_taken, digests_predicted, seed_writes);
      $display("checked %0d digests, %0d mismatches", digests_checked, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
